[design/utf8_punctuation_splitter_unit_assert.svh]
// ----------------------------------------------------------------------------
// utf8 punctuation splitter assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef UTF8_PUNCTUATION_SPLITTER_UNIT_ASSERT_SVH
`define UTF8_PUNCTUATION_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication
`define UPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("splitter check failed: same-cycle implication");

// next-cycle implication
`define UPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("splitter check failed: next-cycle implication");

`endif

[design/upsplit_pkg.sv]
// ----------------------------------------------------------------------------
// upsplit_pkg
// types and codes shared by the punctuation splitter modules
// ----------------------------------------------------------------------------
package upsplit_pkg;

  localparam int unsigned RUN_BYTES = 4;

  typedef enum logic {
    KIND_TOKEN = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  // all results caused by one input item
  typedef struct packed {
    logic [RUN_BYTES-1:0][7:0] bytes;
    logic                      first_starts;
    logic [2:0]                n_bytes;
    logic                      eot;
  } run_t;

endpackage

[design/upsplit_in_if.sv]
// ----------------------------------------------------------------------------
// upsplit_in_if
// text byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface upsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[design/upsplit_out_if.sv]
// ----------------------------------------------------------------------------
// upsplit_out_if
// token byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface upsplit_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       starts_token;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output starts_token,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input starts_token,
                  input last_of_run, output ready);
endinterface

[design/upsplit_core.sv]
// ----------------------------------------------------------------------------
// upsplit_core
// input register, byte classification and tokenizer state
// ----------------------------------------------------------------------------
module upsplit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  upsplit_in_if.sink         in_i,
  input  logic               run_free_i,
  output logic               run_load_o,
  output upsplit_pkg::run_t  run_o
);
  import upsplit_pkg::*;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [2:0] LEAD2_TAG   = 3'h6;
  localparam logic [3:0] LEAD3_TAG   = 4'hE;
  localparam logic [4:0] LEAD4_TAG   = 5'h1E;

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
  endfunction

  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_eot_q;
  logic       in_token_q, in_token_d;
  logic [1:0] needed_q, needed_d;
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [7:0] held_q [3];
  logic       held_we;
  logic [1:0] held_idx;
  logic       a_move;
  logic       in_fire;
  run_t       run;

  assign a_move     = a_valid_q && run_free_i;
  assign in_i.ready = !a_valid_q || a_move;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_token_d       = in_token_q;
    needed_d         = needed_q;
    held_cnt_d       = held_cnt_q;
    held_we          = 1'b0;
    held_idx         = held_cnt_q;
    run.bytes[0]     = held_q[0];
    run.bytes[1]     = held_q[1];
    run.bytes[2]     = held_q[2];
    run.bytes[3]     = a_byte_q;
    run.first_starts = !in_token_q;
    run.n_bytes      = 3'd0;
    run.eot          = a_eot_q;

    if (needed_q != 2'd0) begin
      if (needed_q == 2'd1) begin
        // flush the held sequence followed by this byte
        run.bytes[held_cnt_q] = a_byte_q;
        run.n_bytes           = {1'b0, held_cnt_q} + 3'd1;
        in_token_d            = 1'b1;
        needed_d              = 2'd0;
        held_cnt_d            = 2'd0;
      end else begin
        held_we    = (held_cnt_q != 2'd3);
        held_cnt_d = held_cnt_q + 2'd1;
        needed_d   = needed_q - 2'd1;
      end
    end else if (a_byte_q < ASCII_LIMIT) begin
      run.bytes[0] = a_byte_q;
      if (is_punct(a_byte_q)) begin
        run.n_bytes      = 3'd1;
        run.first_starts = 1'b1;
        in_token_d       = 1'b0;
      end else if (is_space(a_byte_q)) begin
        in_token_d = 1'b0;
      end else begin
        run.n_bytes = 3'd1;
        in_token_d  = 1'b1;
      end
    end else begin
      // lead byte opens a held sequence, strays are dropped
      held_idx = 2'd0;
      if (a_byte_q[7:5] == LEAD2_TAG) begin
        held_we    = 1'b1;
        held_cnt_d = 2'd1;
        needed_d   = 2'd1;
      end else if (a_byte_q[7:4] == LEAD3_TAG) begin
        held_we    = 1'b1;
        held_cnt_d = 2'd1;
        needed_d   = 2'd2;
      end else if (a_byte_q[7:3] == LEAD4_TAG) begin
        held_we    = 1'b1;
        held_cnt_d = 2'd1;
        needed_d   = 2'd3;
      end
    end

    if (a_eot_q) begin
      in_token_d = 1'b0;
      needed_d   = 2'd0;
      held_cnt_d = 2'd0;
    end
  end

  assign run_o      = run;
  assign run_load_o = a_move && (run.n_bytes != 3'd0 || a_eot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      in_token_q <= 1'b0;
      needed_q   <= 2'd0;
      held_cnt_q <= 2'd0;
    end else begin
      if (in_fire) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        in_token_q <= in_token_d;
        needed_q   <= needed_d;
        held_cnt_q <= held_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_byte_q <= in_i.in_byte;
      a_eot_q  <= in_i.end_of_text;
    end
    if (a_move && held_we) begin
      held_q[held_idx] <= a_byte_q;
    end
  end

endmodule

[design/upsplit_emit.sv]
// ----------------------------------------------------------------------------
// upsplit_emit
// result register, one result of a run per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module upsplit_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              run_load_i,
  input  upsplit_pkg::run_t run_i,
  output logic              run_free_o,
  upsplit_out_if.source     out_o
);
  import upsplit_pkg::*;

  logic       valid_q;
  run_t       run_q;
  logic [2:0] idx_q;
  logic [2:0] total;
  logic       is_byte;
  logic       last;
  logic       fire;

  assign total   = run_q.n_bytes + {2'b00, run_q.eot};
  assign is_byte = idx_q < run_q.n_bytes;
  assign last    = (idx_q + 3'd1) == total;
  assign fire    = valid_q && out_o.ready;

  assign run_free_o = !valid_q || (out_o.ready && last);

  assign out_o.valid        = valid_q;
  assign out_o.kind         = is_byte ? KIND_TOKEN : KIND_END;
  assign out_o.out_byte     = is_byte ? run_q.bytes[idx_q[1:0]] : 8'h00;
  assign out_o.starts_token = is_byte && (idx_q == 3'd0) && run_q.first_starts;
  assign out_o.last_of_run  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else if (run_free_o) begin
      valid_q <= run_load_i;
      idx_q   <= 3'd0;
    end else if (fire) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_free_o && run_load_i) begin
      run_q <= run_i;
    end
  end

endmodule

[design/utf8_punctuation_splitter_unit.sv]
// ----------------------------------------------------------------------------
// utf8_punctuation_splitter_unit
// punctuation splitter over a utf-8 byte stream, c-locale classes
// ----------------------------------------------------------------------------
// in_i takes one text byte per item with its end-of-text flag; out_o gives
// token bytes, each flagged when it opens a token, plus one end marker per
// text. last_of_run marks the final result caused by one input item.
// an item passes the input register, then the result register, before its
// first result is valid.
// throughput: one result per cycle while the receiver is ready. an item that
// gives zero or one result leaves room for the next item every cycle while
// the receiver is ready; a completed multibyte sequence holds the result
// register until each of its bytes, and any end marker, has been taken,
// which is what sets the rate on such items. the input register takes a
// further item meanwhile.
// reset clears the token and sequence state and empties both registers.
// when the receiver stalls, the current result holds and the input side
// stops once its register is full.
// ----------------------------------------------------------------------------
module utf8_punctuation_splitter_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  upsplit_in_if.sink    in_i,
  upsplit_out_if.source out_o
);
  import upsplit_pkg::*;

  `include "utf8_punctuation_splitter_unit_assert.svh"

  run_t run;
  logic run_load;
  logic run_free;

  upsplit_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .run_free_i (run_free),
    .run_load_o (run_load),
    .run_o      (run)
  );

  upsplit_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .run_load_i (run_load),
    .run_i      (run),
    .run_free_o (run_free),
    .out_o      (out_o)
  );

  // a run never overwrites results still waiting
  `UPS_ASSERT_IMP(a_load_free, clk_i, rst_ni, run_load, run_free)
  // the end marker closes its run
  `UPS_ASSERT_IMP(a_end_last, clk_i, rst_ni, out_o.valid && out_o.kind == KIND_END, out_o.last_of_run)
  // end marker never opens a token
  `UPS_ASSERT_IMP(a_end_nostart, clk_i, rst_ni, out_o.valid && out_o.kind == KIND_END, !out_o.starts_token)
  // taking the last result with nothing loaded empties the output
  `UPS_ASSERT_NXT(a_drain, clk_i, rst_ni, out_o.valid && out_o.ready && out_o.last_of_run && !run_load, !out_o.valid)

endmodule

[dv/upsplit_token_checker.sv]
// ----------------------------------------------------------------------------
// upsplit_token_checker
// watches the text and token channels of the punctuation splitter, works out
// the token bytes each accepted text byte should give and compares every
// accepted result with the oldest one still due
// ----------------------------------------------------------------------------
module upsplit_token_checker
  import upsplit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  upsplit_in_if       text_i,
  upsplit_out_if      token_i,
  output int unsigned due_count_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_CAP = 200;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       opens;
    logic       last;
  } token_res_t;

  // splitter state as the block should hold it
  logic       open_token;
  logic [1:0] owed;
  logic [1:0] held_n;
  logic [7:0] held [3];

  token_res_t  tokens_due [$];
  int unsigned results_seen;
  int unsigned misses;

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
  endfunction

  // a byte that joins the open token, or opens one
  function automatic token_res_t token_byte(input logic [7:0] v);
    token_res_t r;
    r.kind  = KIND_TOKEN;
    r.value = v;
    r.opens = !open_token;
    r.last  = 1'b0;
    open_token = 1'b1;
    return r;
  endfunction

  function automatic void split_byte(input logic [7:0] b, input logic eot);
    token_res_t run [$];
    token_res_t mark;
    logic [1:0] need;
    int         i;
    if (owed != 2'd0) begin
      // a held sequence swallows the byte whatever it is
      if (owed == 2'd1) begin
        for (i = 0; i < held_n; i++) run = {run, token_byte(held[i])};
        run    = {run, token_byte(b)};
        owed   = 2'd0;
        held_n = 2'd0;
      end else begin
        if (held_n < 2'd3) held[held_n] = b;
        held_n = held_n + 2'd1;
        owed   = owed - 2'd1;
      end
    end else if (!b[7]) begin
      if (is_punct(b)) begin
        mark = '{KIND_TOKEN, b, 1'b1, 1'b0};
        run  = {run, mark};
        open_token = 1'b0;
      end else if (is_space(b)) begin
        open_token = 1'b0;
      end else begin
        run = {run, token_byte(b)};
      end
    end else begin
      if (b[7:5] == 3'b110) need = 2'd1;
      else if (b[7:4] == 4'b1110) need = 2'd2;
      else if (b[7:3] == 5'b11110) need = 2'd3;
      else need = 2'd0;
      // stray continuation and 0xf8+ bytes leave the token open
      if (need != 2'd0) begin
        held[0] = b;
        held_n  = 2'd1;
        owed    = need;
      end
    end
    if (eot) begin
      mark = '{KIND_END, 8'h00, 1'b0, 1'b0};
      run  = {run, mark};
      open_token = 1'b0;
      owed       = 2'd0;
      held_n     = 2'd0;
    end
    if (run.size() != 0) run[run.size()-1].last = 1'b1;
    tokens_due = {tokens_due, run};
  endfunction

  task automatic report_mismatch(input string why, input token_res_t want,
                                 input token_res_t seen);
    if (misses < PRINT_CAP)
      $display("%0t ns result %0d: %s: kind %0d/%0d byte %02h/%02h start %0b/%0b last %0b/%0b",
               $time, results_seen, why, want.kind, seen.kind, want.value, seen.value,
               want.opens, seen.opens, want.last, seen.last);
    misses++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_res_t seen;
    token_res_t want;
    if (!rst_ni) begin
      open_token = 1'b0;
      owed       = 2'd0;
      held_n     = 2'd0;
      held       = '{default: 8'h00};
      tokens_due.delete();
      results_seen = 0;
      misses       = 0;
      due_count_o  <= 0;
      fail_count_o <= 0;
    end else begin
      // results first: one accepted at this edge can never stem from the item
      // accepted at the same edge
      if (token_i.valid && token_i.ready) begin
        seen = '{kind_e'(token_i.kind), token_i.out_byte, token_i.starts_token,
                 token_i.last_of_run};
        if (tokens_due.size() == 0) begin
          report_mismatch("result with nothing due", seen, seen);
        end else begin
          want = tokens_due.pop_front();
          if (seen.kind !== want.kind || seen.value !== want.value ||
              seen.opens !== want.opens || seen.last !== want.last)
            report_mismatch("field mismatch (due/seen)", want, seen);
        end
        results_seen++;
      end
      if (text_i.valid && text_i.ready) split_byte(text_i.in_byte, text_i.end_of_text);
      due_count_o  <= tokens_due.size();
      fail_count_o <= misses;
    end
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives text bytes into the punctuation splitter: a directed opening over
// the byte classes and utf-8 corner cases, then mostly well-formed random
// text with noise, random idling on both sides, a long receiver hold-off and
// a sender pause; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 304;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic clk;
  logic rst_n;
  logic steady;        // no idling on either side while set
  logic hold_pending;  // asks the receiver for one long hold-off

  int unsigned due_count;
  int unsigned fail_count;

  upsplit_in_if  in_if ();
  upsplit_out_if out_if ();

  // {end_of_text, byte}
  logic [8:0] directed_text [$] = '{
    9'h061, 9'h062, 9'h080, 9'h0FF, 9'h063,  // strays inside a token
    9'h020, 9'h021, 9'h07E, 9'h000, 9'h07F, 9'h009,
    9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,  // two and three byte sequences
    9'h0C3, 9'h020,                          // held lead takes a space
    9'h0F8, 9'h0E2, 9'h182,                  // cut short by end of text
    9'h10D,
    9'h0F0, 9'h09F, 9'h098, 9'h180           // four bytes plus end marker
  };

  utf8_punctuation_splitter_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  upsplit_token_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .text_i       (in_if),
    .token_i      (out_if),
    .due_count_o  (due_count),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.in_byte     <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  // receiver
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end
      out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: cycles without any handshake
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned owed;
    int unsigned r;
    logic [7:0]  b;
    logic        eot;
    rst_n              = 1'b0;
    steady             = 1'b0;
    hold_pending       = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.in_byte     <= 8'h00;
    in_if.end_of_text <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_text[i]) send_item(directed_text[i][7:0], directed_text[i][8]);
    wait_for_results();

    sent = 0;
    owed = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (owed != 0) begin
        // continuation bytes, now and then a broken one
        b = (r < 5) ? 8'($urandom_range(255)) : {2'b10, 6'($urandom_range(63))};
        owed--;
      end else if (r < 35) begin
        case ($urandom_range(2))
          0:       b = 8'($urandom_range(8'h39, 8'h30));
          1:       b = 8'($urandom_range(8'h5A, 8'h41));
          default: b = 8'($urandom_range(8'h7A, 8'h61));
        endcase
      end else if (r < 48) begin
        b = ($urandom_range(6) == 0) ? 8'h20 : 8'($urandom_range(8'h0D, 8'h09));
      end else if (r < 62) begin
        case ($urandom_range(3))
          0:       b = 8'($urandom_range(8'h2F, 8'h21));
          1:       b = 8'($urandom_range(8'h40, 8'h3A));
          2:       b = 8'($urandom_range(8'h60, 8'h5B));
          default: b = 8'($urandom_range(8'h7E, 8'h7B));
        endcase
      end else if (r < 72) begin
        b    = 8'($urandom_range(8'hDF, 8'hC0));
        owed = 1;
      end else if (r < 80) begin
        b    = 8'($urandom_range(8'hEF, 8'hE0));
        owed = 2;
      end else if (r < 86) begin
        b    = 8'($urandom_range(8'hF7, 8'hF0));
        owed = 3;
      end else if (r < 96) begin
        b = 8'($urandom_range(255));
      end else begin
        b = ($urandom_range(1) == 0) ? {2'b10, 6'($urandom_range(63))}
                                     : 8'($urandom_range(8'hFF, 8'hF8));
      end
      eot = ($urandom_range(99) < 4);
      if (eot) owed = 0;

      if (sent == 60) hold_pending = 1'b1;
      steady = (sent >= 120 && sent < 200);
      if (sent == 260) wait_for_results();

      send_item(b, eot);
      sent++;
    end
    steady = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
